### sv/fura_pkg.sv
// fura_pkg: shared types and constants of the fenced upload ring allocator
// no dependencies; used by the interfaces and the top level
package fura_pkg;

  localparam int unsigned SIZE_W   = 33;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned OFF_W    = 32;
  localparam int unsigned ALIGN_W  = 5;
  localparam int unsigned SPANS_W  = 4;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 64;

  // largest ring the block handles, writes above it saturate
  localparam logic [SIZE_W-1:0] RING_LIMIT = 33'h1_0000_0000;

  localparam logic [PADDR_W-1:0] REG_RING_SIZE = 4'h0;
  localparam logic [PADDR_W-1:0] REG_BASE_ADDR = 4'h8;

  typedef enum logic [1:0] {
    ACT_ALLOC    = 2'd0,
    ACT_SUBMIT   = 2'd1,
    ACT_COMPLETE = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_SIZE  = 2'd1,
    STAT_EXHAUSTED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLACE,
    S_SUBMIT,
    S_FETCH,
    S_RETIRE,
    S_REPLY
  } fsm_e;

endpackage

### sv/fura_if.sv
// fura_item_if / fura_result_if: valid/ready channels of the ring allocator
// depends on fura_pkg for field widths
interface fura_item_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [fura_pkg::SIZE_W-1:0]  alloc_size;
  logic [fura_pkg::ALIGN_W-1:0] align_log2;
  logic [fura_pkg::ADDR_W-1:0]  fence_value;

  modport source (output valid, action, alloc_size, align_log2, fence_value, input ready);
  modport sink   (input valid, action, alloc_size, align_log2, fence_value, output ready);
endinterface

interface fura_result_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [fura_pkg::OFF_W-1:0]   offset;
  logic [fura_pkg::ADDR_W-1:0]  gpu_address;
  logic [fura_pkg::SPANS_W-1:0] spans_in_flight;

  modport source (output valid, status, offset, gpu_address, spans_in_flight, input ready);
  modport sink   (input valid, status, offset, gpu_address, spans_in_flight, output ready);
endinterface

### sv/fura_span_mem.sv
// fura_span_mem: span queue storage, one write port and one read port
// read data is registered; no package dependency
module fura_span_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 81,
  parameter int unsigned AW    = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/fenced_upload_ring_allocator_top.sv
// Ring allocator over a byte buffer with fence-tracked release. Allocate, submit and the
// unused action code pass through their own working state (place, submit or reply) before
// their result is registered in the output slot; complete alternates fetch and retire per
// retired span, since every span is read from the registered span memory and checked on
// its own. An item is accepted only when the previous one has finished; a result that is not
// taken holds the block in its last step until the output slot frees.
// depends on fura_pkg, fura_if and fura_span_mem
module fenced_upload_ring_allocator_top #(
  parameter int unsigned MAX_SPAN_ENTRIES = 8,
  parameter int unsigned FENCE_BITS       = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fura_item_if.sink                      in_i,
  fura_result_if.source                  out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fura_pkg::PADDR_W-1:0]   paddr,
  input  logic [fura_pkg::PDATA_W-1:0]   pwdata,
  output logic [fura_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned SZ    = fura_pkg::SIZE_W;
  localparam int unsigned FW    = FENCE_BITS;
  localparam int unsigned PTR_W = (MAX_SPAN_ENTRIES > 1) ? $clog2(MAX_SPAN_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SPAN_ENTRIES + 1);
  localparam int unsigned SUM_W = PTR_W + 1;
  localparam int unsigned MEM_W = SZ + FW;
  localparam int unsigned ALN_W = SZ + 1;
  localparam int unsigned END_W = SZ + 2;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SPAN_ENTRIES);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_SPAN_ENTRIES - 1);

  fura_pkg::fsm_e    state_q, state_d;
  fura_pkg::action_e act_q;

  logic [SZ-1:0]                   ring_q, ring_d;
  logic [fura_pkg::ADDR_W-1:0]     base_q;
  logic [SZ-1:0]                   head_q, head_d;
  logic [SZ-1:0]                   tail_q, tail_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [PTR_W-1:0]                rd_ptr_q, rd_ptr_d, rd_ptr_inc;
  logic [SZ-1:0]                   size_q;
  logic [FW-1:0]                   fence_q, fence_in;
  logic [ALN_W-1:0]                aligned_q, aligned_d;
  logic [fura_pkg::OFF_W-1:0]      amask;

  logic                            in_fire, cfg_we, push, push_ok;
  logic [SZ-1:0]                   ring_wr;

  logic                            bad, fits, exhaust;
  logic [END_W-1:0]                end_sum, grant_end;
  logic [ALN_W-1:0]                grant;

  logic [SUM_W-1:0]                wr_sum;
  logic [PTR_W-1:0]                wr_idx;
  logic                            mem_we;
  logic [MEM_W-1:0]                mem_wdata, mem_rdata;
  logic [SZ-1:0]                   span_head_rd;
  logic [FW-1:0]                   span_fence_rd;
  logic                            retire_go;

  fura_pkg::status_e               res_status;
  logic [fura_pkg::OFF_W-1:0]      res_offset;
  logic [fura_pkg::ADDR_W-1:0]     res_gpu;

  logic                            out_valid_q;
  logic [1:0]                      out_status_q;
  logic [fura_pkg::OFF_W-1:0]      out_offset_q;
  logic [fura_pkg::ADDR_W-1:0]     out_gpu_q;
  logic [fura_pkg::SPANS_W-1:0]    out_spans_q;

  // ---------------------------------------------------------------- handshakes
  assign in_i.ready = (state_q == fura_pkg::S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign push_ok    = !out_valid_q || out_o.ready;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  assign ring_wr = (pwdata[SZ-1:0] > fura_pkg::RING_LIMIT) ?
                   fura_pkg::RING_LIMIT : pwdata[SZ-1:0];

  always_comb begin
    case (paddr)
      fura_pkg::REG_RING_SIZE: prdata = fura_pkg::PDATA_W'(ring_q);
      fura_pkg::REG_BASE_ADDR: prdata = fura_pkg::PDATA_W'(base_q);
      default:                 prdata = '0;
    endcase
  end

  // fence is kept modulo 2^FENCE_BITS
  assign fence_in = FW'({16'd0, in_i.fence_value});

  // ---------------------------------------------------------------- span memory
  assign rd_ptr_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
  assign wr_sum     = SUM_W'(rd_ptr_q) + SUM_W'(count_q);
  assign wr_idx     = (wr_sum >= SUM_W'(MAX_SPAN_ENTRIES)) ?
                      PTR_W'(wr_sum - SUM_W'(MAX_SPAN_ENTRIES)) : PTR_W'(wr_sum);
  assign mem_wdata  = {head_q, fence_q};

  fura_span_mem #(
    .DEPTH (MAX_SPAN_ENTRIES),
    .WIDTH (MEM_W),
    .AW    (PTR_W)
  ) u_span_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_idx),
    .wdata_i (mem_wdata),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  assign span_head_rd  = mem_rdata[MEM_W-1:FW];
  assign span_fence_rd = mem_rdata[FW-1:0];
  assign retire_go     = (count_q != '0) && (span_fence_rd <= fence_q);

  // ---------------------------------------------------------------- allocate math
  assign amask = ~({fura_pkg::OFF_W{1'b1}} << in_i.align_log2);

  assign bad       = (ring_q == '0) || (size_q == '0) || (size_q > ring_q);
  assign end_sum   = END_W'(aligned_q) + END_W'(size_q);
  assign fits      = (end_sum <= END_W'(ring_q));
  assign grant     = fits ? aligned_q : '0;
  assign grant_end = fits ? end_sum : END_W'(size_q);
  // a wrapped grant must stay below the oldest in-flight data
  assign exhaust   = (count_q != '0) && (grant < ALN_W'(head_q)) &&
                     (grant_end > END_W'(tail_q));

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fura_pkg::S_IDLE: begin
        if (in_fire) begin
          case (fura_pkg::action_e'(in_i.action))
            fura_pkg::ACT_ALLOC:    state_d = fura_pkg::S_PLACE;
            fura_pkg::ACT_SUBMIT:   state_d = fura_pkg::S_SUBMIT;
            fura_pkg::ACT_COMPLETE: state_d = fura_pkg::S_FETCH;
            default:                state_d = fura_pkg::S_REPLY;
          endcase
        end
      end
      fura_pkg::S_FETCH:  state_d = fura_pkg::S_RETIRE;
      fura_pkg::S_RETIRE: begin
        if (retire_go) begin
          state_d = fura_pkg::S_FETCH;
        end else if (push_ok) begin
          state_d = fura_pkg::S_IDLE;
        end
      end
      fura_pkg::S_PLACE, fura_pkg::S_SUBMIT, fura_pkg::S_REPLY: begin
        if (push_ok) begin
          state_d = fura_pkg::S_IDLE;
        end
      end
      default: state_d = fura_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    ring_d     = ring_q;
    aligned_d  = aligned_q;
    mem_we     = 1'b0;
    push       = 1'b0;
    res_status = fura_pkg::STAT_OK;
    res_offset = '0;
    res_gpu    = '0;
    case (state_q)
      fura_pkg::S_IDLE: begin
        aligned_d = (ALN_W'(head_q) + ALN_W'(amask)) & ~ALN_W'(amask);
      end
      fura_pkg::S_PLACE: begin
        if (push_ok) begin
          push = 1'b1;
          if (bad) begin
            res_status = fura_pkg::STAT_BAD_SIZE;
          end else if (exhaust) begin
            res_status = fura_pkg::STAT_EXHAUSTED;
          end else begin
            head_d     = grant_end[SZ-1:0];
            res_offset = grant[fura_pkg::OFF_W-1:0];
            res_gpu    = base_q + fura_pkg::ADDR_W'(grant[fura_pkg::OFF_W-1:0]);
          end
        end
      end
      fura_pkg::S_SUBMIT: begin
        if (push_ok) begin
          push   = 1'b1;
          mem_we = 1'b1;
          // full queue: the new span overwrites the oldest one
          if (count_q == CNT_MAX) begin
            rd_ptr_d = rd_ptr_inc;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      fura_pkg::S_RETIRE: begin
        if (retire_go) begin
          tail_d   = span_head_rd;
          rd_ptr_d = rd_ptr_inc;
          count_d  = count_q - CNT_W'(1);
        end else if (push_ok) begin
          push = 1'b1;
          if (count_q == '0) begin
            tail_d = head_q;
          end
        end
      end
      fura_pkg::S_REPLY: begin
        push = push_ok;
      end
      default: ;
    endcase
    if (cfg_we && (paddr == fura_pkg::REG_RING_SIZE)) begin
      ring_d   = ring_wr;
      head_d   = '0;
      tail_d   = '0;
      count_d  = '0;
      rd_ptr_d = '0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fura_pkg::S_IDLE;
      ring_q    <= '0;
      base_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      rd_ptr_q  <= '0;
    end else begin
      state_q   <= state_d;
      ring_q    <= ring_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      rd_ptr_q  <= rd_ptr_d;
      if (cfg_we && (paddr == fura_pkg::REG_BASE_ADDR)) begin
        base_q <= pwdata[fura_pkg::ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    aligned_q <= aligned_d;
    if (in_fire) begin
      act_q   <= fura_pkg::action_e'(in_i.action);
      size_q  <= in_i.alloc_size;
      fence_q <= fence_in;
    end
  end

  // output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_status_q <= res_status;
      out_offset_q <= res_offset;
      out_gpu_q    <= res_gpu;
      out_spans_q  <= fura_pkg::SPANS_W'(count_d);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.offset          = out_offset_q;
  assign out_o.gpu_address     = out_gpu_q;
  assign out_o.spans_in_flight = out_spans_q;

  // ---------------------------------------------------------------- assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("span count above queue depth");

  a_head_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= ring_q)
    else $error("head offset beyond ring size");

  a_retire_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fura_pkg::S_RETIRE && retire_go && !cfg_we)
    |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("retire did not drop exactly one span");

  a_full_submit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fura_pkg::S_SUBMIT && push && count_q == CNT_MAX && !cfg_we)
    |=> count_q == CNT_MAX && act_q == fura_pkg::ACT_SUBMIT)
    else $error("submit into full queue changed span count");

endmodule
